>>> hw/rtl/segi_pkg.sv
// Shared constants for the segment intersection block.
// No dependencies; used by every module under hw/rtl except segi_queue.
package segi_pkg;

    localparam int IN_BITS     = 16;   // width of each endpoint port
    localparam int OUT_BITS    = 24;   // width of each crossing coordinate
    localparam int QUEUE_DEPTH = 4;    // entries in each decoupling queue
    // s0 magnitude, s1 overflow check, one stage per quotient bit, final clamp
    localparam int DIV_LAT     = OUT_BITS + 3;

endpackage

>>> hw/rtl/segment_intersection.sv
// Segment intersection: one item of two segments in, one result out, one item
// per clock sustained while neither side stalls. The accepting edge loads the
// first of 5 front stages; the item then enters the middle queue, passes the
// OUT_BITS+3 divider stages and enters the output queue, in that order. The
// one-bit-per-stage divider makes up most of the pipeline. Each side stalls on
// its own behind 4-entry queues.
// Uses segi_pkg, segi_front, segi_queue, segi_back.
module segment_intersection #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [segi_pkg::IN_BITS-1:0]         ax0, ay0, ax1, ay1,
    input  logic [segi_pkg::IN_BITS-1:0]         bx0, by0, bx1, by1,
    output logic                                 empty,
    input  logic                                 pop,
    output logic                                 hit,
    output logic                                 parallel,
    output logic signed [segi_pkg::OUT_BITS-1:0] cross_x,
    output logic signed [segi_pkg::OUT_BITS-1:0] cross_y,
    output logic                                 point_saturated
);
    localparam int C    = COORD_BITS;
    localparam int NW   = 3 * C + 3;
    localparam int DETW = 2 * C + 3;
    localparam int QW   = 2 + 2 * NW + DETW;
    localparam int OB   = segi_pkg::OUT_BITS;
    localparam int RW   = 3 + 2 * OB;

    logic f_en, f_valid, f_hit, f_par;
    logic signed [NW-1:0]   f_nx, f_ny;
    logic signed [DETW-1:0] f_det;
    logic q_full, q_empty;
    logic [QW-1:0] q_dout;

    logic b_en, b_valid, b_hit, b_par, b_sat;
    logic signed [OB-1:0] b_x, b_y;
    logic o_full;
    logic [RW-1:0] o_dout;

    assign f_en = !(f_valid && q_full);
    assign full = !f_en;

    segi_front #(.C(C)) u_front (
        .clk (clk), .rst_n (rst_n), .en (f_en), .in_valid (push),
        .ax0 (ax0), .ay0 (ay0), .ax1 (ax1), .ay1 (ay1),
        .bx0 (bx0), .by0 (by0), .bx1 (bx1), .by1 (by1),
        .out_valid (f_valid), .out_hit (f_hit), .out_par (f_par),
        .out_numx (f_nx), .out_numy (f_ny), .out_det (f_det)
    );

    segi_queue #(.W(QW), .DEPTH(segi_pkg::QUEUE_DEPTH)) u_mid_q (
        .clk (clk), .rst_n (rst_n),
        .push (f_valid && f_en), .din ({f_hit, f_par, f_nx, f_ny, f_det}),
        .full (q_full), .pop (b_en), .dout (q_dout), .empty (q_empty)
    );

    assign b_en = !(b_valid && o_full);

    segi_back #(.C(C), .F(FRAC_BITS)) u_back (
        .clk (clk), .rst_n (rst_n), .en (b_en), .in_valid (!q_empty),
        .in_hit  (q_dout[QW-1]),
        .in_par  (q_dout[QW-2]),
        .in_numx ($signed(q_dout[QW-3 -: NW])),
        .in_numy ($signed(q_dout[DETW+NW-1 -: NW])),
        .in_det  ($signed(q_dout[DETW-1:0])),
        .out_valid (b_valid), .out_hit (b_hit), .out_par (b_par),
        .out_x (b_x), .out_y (b_y), .out_sat (b_sat)
    );

    segi_queue #(.W(RW), .DEPTH(segi_pkg::QUEUE_DEPTH)) u_out_q (
        .clk (clk), .rst_n (rst_n),
        .push (b_valid && b_en), .din ({b_hit, b_par, b_sat, b_x, b_y}),
        .full (o_full), .pop (pop), .dout (o_dout), .empty (empty)
    );

    assign hit             = o_dout[RW-1];
    assign parallel        = o_dout[RW-2];
    assign point_saturated = o_dout[RW-3];
    assign cross_x         = $signed(o_dout[2*OB-1:OB]);
    assign cross_y         = $signed(o_dout[OB-1:0]);

endmodule

>>> hw/rtl/segi_queue.sv
// Small register FIFO used between the front and back halves and at the output.
// Depends on nothing but its parameters.
module segi_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= din;
        end
    end

endmodule

>>> hw/rtl/segi_front.sv
// Front half: takes endpoint items, computes determinant, Cramer numerators
// and the straddle tests over five stages. Uses segi_pkg.
module segi_front #(
    parameter int C = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [segi_pkg::IN_BITS-1:0]      ax0, ay0, ax1, ay1,
    input  logic [segi_pkg::IN_BITS-1:0]      bx0, by0, bx1, by1,
    output logic                              out_valid,
    output logic                              out_hit,
    output logic                              out_par,
    output logic signed [3*C+2:0]             out_numx,
    output logic signed [3*C+2:0]             out_numy,
    output logic signed [2*C+2:0]             out_det
);
    localparam int IW   = segi_pkg::IN_BITS;
    localparam int TW   = (C < IW) ? C : IW;
    localparam int DW   = C + 1;
    localparam int PW   = 2 * DW;
    localparam int DETW = 2 * C + 3;
    localparam int DAW  = 2 * C + 1;
    localparam int NW   = 3 * C + 3;

    logic [4:0] v_reg;

    // stage 1: coordinates and differences
    logic signed [C-1:0]  cax0, cay0, cax1, cay1, cbx0, cby0, cbx1, cby1;
    logic signed [C-1:0]  s1_ax0_reg, s1_ay0_reg, s1_ax1_reg, s1_ay1_reg;
    logic signed [C-1:0]  s1_bx0_reg, s1_by0_reg, s1_bx1_reg, s1_by1_reg;
    logic signed [DW-1:0] s1_xda_reg, s1_yda_reg, s1_xdb_reg, s1_ydb_reg;
    logic signed [DW-1:0] s1_ax_reg, s1_ay_reg, s1_bx_reg, s1_by_reg;
    logic signed [DW-1:0] s1_e0x_reg, s1_e0y_reg, s1_e1x_reg, s1_e1y_reg;
    logic signed [DW-1:0] s1_e2x_reg, s1_e2y_reg, s1_e3x_reg, s1_e3y_reg;

    // stage 2: products
    logic signed [PW-1:0]   s2_pd1_reg, s2_pd2_reg;
    logic signed [2*C-1:0]  s2_pa1_reg, s2_pa2_reg, s2_pb1_reg, s2_pb2_reg;
    logic signed [PW-1:0]   s2_l0a_reg, s2_l0b_reg, s2_l1a_reg, s2_l1b_reg;
    logic signed [PW-1:0]   s2_l2a_reg, s2_l2b_reg, s2_l3a_reg, s2_l3b_reg;
    logic signed [DW-1:0]   s2_xda_reg, s2_yda_reg, s2_xdb_reg, s2_ydb_reg;

    // stage 3: determinant, cross terms, hit
    logic signed [PW:0]     l0, l1, l2, l3;
    logic signed [DETW-1:0] s3_det_reg;
    logic signed [DAW-1:0]  s3_da_reg, s3_db_reg;
    logic                   s3_hit_reg, s3_par_reg;
    logic signed [DW-1:0]   s3_xda_reg, s3_yda_reg, s3_xdb_reg, s3_ydb_reg;

    // stage 4: numerator products
    logic signed [DAW+DW-1:0] s4_px1_reg, s4_px2_reg, s4_py1_reg, s4_py2_reg;
    logic signed [DETW-1:0]   s4_det_reg;
    logic                     s4_hit_reg, s4_par_reg;

    // stage 5: numerators
    logic signed [NW-1:0]   s5_nx_reg, s5_ny_reg;
    logic signed [DETW-1:0] s5_det_reg;
    logic                   s5_hit_reg, s5_par_reg;

    // bits above the port width read as zero, so a wide coordinate has no sign there
    function automatic logic signed [C-1:0] to_coord(logic [IW-1:0] v);
        if (C > IW)
        begin
            return C'(v);
        end
        return C'($signed(v[TW-1:0]));
    endfunction

    assign cax0 = to_coord(ax0);
    assign cay0 = to_coord(ay0);
    assign cax1 = to_coord(ax1);
    assign cay1 = to_coord(ay1);
    assign cbx0 = to_coord(bx0);
    assign cby0 = to_coord(by0);
    assign cbx1 = to_coord(bx1);
    assign cby1 = to_coord(by1);

    assign l0 = (PW+1)'(s2_l0a_reg) - (PW+1)'(s2_l0b_reg);
    assign l1 = (PW+1)'(s2_l1a_reg) - (PW+1)'(s2_l1b_reg);
    assign l2 = (PW+1)'(s2_l2a_reg) - (PW+1)'(s2_l2b_reg);
    assign l3 = (PW+1)'(s2_l3a_reg) - (PW+1)'(s2_l3b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ax0_reg <= cax0;
            s1_ay0_reg <= cay0;
            s1_ax1_reg <= cax1;
            s1_ay1_reg <= cay1;
            s1_bx0_reg <= cbx0;
            s1_by0_reg <= cby0;
            s1_bx1_reg <= cbx1;
            s1_by1_reg <= cby1;
            s1_xda_reg <= DW'(cax0) - DW'(cax1);
            s1_yda_reg <= DW'(cay0) - DW'(cay1);
            s1_xdb_reg <= DW'(cbx0) - DW'(cbx1);
            s1_ydb_reg <= DW'(cby0) - DW'(cby1);
            // segment direction vectors p1 - p0
            s1_ax_reg  <= DW'(cax1) - DW'(cax0);
            s1_ay_reg  <= DW'(cay1) - DW'(cay0);
            s1_bx_reg  <= DW'(cbx1) - DW'(cbx0);
            s1_by_reg  <= DW'(cby1) - DW'(cby0);
            // p0 - e for the four endpoint tests
            s1_e0x_reg <= DW'(cax0) - DW'(cbx0);
            s1_e0y_reg <= DW'(cay0) - DW'(cby0);
            s1_e1x_reg <= DW'(cax0) - DW'(cbx1);
            s1_e1y_reg <= DW'(cay0) - DW'(cby1);
            s1_e2x_reg <= DW'(cbx0) - DW'(cax0);
            s1_e2y_reg <= DW'(cby0) - DW'(cay0);
            s1_e3x_reg <= DW'(cbx0) - DW'(cax1);
            s1_e3y_reg <= DW'(cby0) - DW'(cay1);

            s2_pd1_reg <= s1_xda_reg * s1_ydb_reg;
            s2_pd2_reg <= s1_xdb_reg * s1_yda_reg;
            s2_pa1_reg <= s1_ax0_reg * s1_ay1_reg;
            s2_pa2_reg <= s1_ay0_reg * s1_ax1_reg;
            s2_pb1_reg <= s1_bx0_reg * s1_by1_reg;
            s2_pb2_reg <= s1_by0_reg * s1_bx1_reg;
            s2_l0a_reg <= s1_e0x_reg * s1_ay_reg;
            s2_l0b_reg <= s1_e0y_reg * s1_ax_reg;
            s2_l1a_reg <= s1_e1x_reg * s1_ay_reg;
            s2_l1b_reg <= s1_e1y_reg * s1_ax_reg;
            s2_l2a_reg <= s1_e2x_reg * s1_by_reg;
            s2_l2b_reg <= s1_e2y_reg * s1_bx_reg;
            s2_l3a_reg <= s1_e3x_reg * s1_by_reg;
            s2_l3b_reg <= s1_e3y_reg * s1_bx_reg;
            s2_xda_reg <= s1_xda_reg;
            s2_yda_reg <= s1_yda_reg;
            s2_xdb_reg <= s1_xdb_reg;
            s2_ydb_reg <= s1_ydb_reg;

            s3_det_reg <= DETW'(s2_pd1_reg) - DETW'(s2_pd2_reg);
            s3_da_reg  <= DAW'(s2_pa1_reg) - DAW'(s2_pa2_reg);
            s3_db_reg  <= DAW'(s2_pb1_reg) - DAW'(s2_pb2_reg);
            s3_par_reg <= (s2_pd1_reg == s2_pd2_reg);
            // strict left test; zero orientation counts as not left
            s3_hit_reg <= (s2_pd1_reg != s2_pd2_reg)
                          && ((l0 > 0) != (l1 > 0)) && ((l2 > 0) != (l3 > 0));
            s3_xda_reg <= s2_xda_reg;
            s3_yda_reg <= s2_yda_reg;
            s3_xdb_reg <= s2_xdb_reg;
            s3_ydb_reg <= s2_ydb_reg;

            s4_px1_reg <= s3_da_reg * s3_xdb_reg;
            s4_px2_reg <= s3_db_reg * s3_xda_reg;
            s4_py1_reg <= s3_da_reg * s3_ydb_reg;
            s4_py2_reg <= s3_db_reg * s3_yda_reg;
            s4_det_reg <= s3_det_reg;
            s4_hit_reg <= s3_hit_reg;
            s4_par_reg <= s3_par_reg;

            s5_nx_reg  <= NW'(s4_px1_reg) - NW'(s4_px2_reg);
            s5_ny_reg  <= NW'(s4_py1_reg) - NW'(s4_py2_reg);
            s5_det_reg <= s4_det_reg;
            s5_hit_reg <= s4_hit_reg;
            s5_par_reg <= s4_par_reg;
        end
    end

    assign out_valid = v_reg[4];
    assign out_hit   = s5_hit_reg;
    assign out_par   = s5_par_reg;
    assign out_numx  = s5_nx_reg;
    assign out_numy  = s5_ny_reg;
    assign out_det   = s5_det_reg;

endmodule

>>> hw/rtl/segi_div.sv
// Pipelined restoring divider: (num << F) / den truncated toward zero,
// clamped to OUT_BITS. One quotient bit per stage. Uses segi_pkg.
module segi_div #(
    parameter int C = 16,
    parameter int F = 8
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [3*C+2:0]                num,
    input  logic signed [2*C+2:0]                den,
    output logic signed [segi_pkg::OUT_BITS-1:0] q,
    output logic                                 sat
);
    localparam int OB   = segi_pkg::OUT_BITS;
    localparam int NW   = 3 * C + 3;
    localparam int DETW = 2 * C + 3;
    localparam int HW   = NW + F;
    localparam int MW   = HW + OB;

    logic [NW-1:0]   m0_reg;
    logic [DETW-1:0] d0_reg;
    logic            n0_reg;

    logic [MW-1:0]   mfull;
    logic [HW-1:0]   hi;

    logic [DETW-1:0] r_reg  [OB+1];
    logic [DETW-1:0] d_reg  [OB+1];
    logic [OB-1:0]   lo_reg [OB+1];
    logic [OB-1:0]   qb_reg [OB+1];
    logic            ng_reg [OB+1];
    logic            ov_reg [OB+1];

    logic [OB-1:0]   lim, qv;
    logic            sat_c;
    logic signed [OB-1:0] q_reg;
    logic            sat_reg;

    assign mfull = MW'(m0_reg) << F;
    assign hi    = mfull[MW-1:OB];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_reg <= (num < 0) ? NW'(-num) : NW'(num);
            d0_reg <= (den < 0) ? DETW'(-den) : DETW'(den);
            n0_reg <= (num < 0) != (den < 0);

            // quotient of 2^OUT_BITS or more cannot fit
            ov_reg[0] <= (hi >= HW'(d0_reg));
            r_reg[0]  <= (hi >= HW'(d0_reg)) ? '0 : hi[DETW-1:0];
            d_reg[0]  <= d0_reg;
            lo_reg[0] <= mfull[OB-1:0];
            qb_reg[0] <= '0;
            ng_reg[0] <= n0_reg;
        end
    end

    for (genvar k = 1; k <= OB; k++)
    begin : g_stage
        logic [DETW:0] t;
        assign t = {r_reg[k-1], lo_reg[k-1][OB-1]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (t >= (DETW+1)'(d_reg[k-1]))
                begin
                    r_reg[k] <= DETW'(t - (DETW+1)'(d_reg[k-1]));
                end
                else
                begin
                    r_reg[k] <= t[DETW-1:0];
                end
                qb_reg[k] <= {qb_reg[k-1][OB-2:0], t >= (DETW+1)'(d_reg[k-1])};
                lo_reg[k] <= lo_reg[k-1] << 1;
                d_reg[k]  <= d_reg[k-1];
                ng_reg[k] <= ng_reg[k-1];
                ov_reg[k] <= ov_reg[k-1];
            end
        end
    end

    always_comb
    begin
        lim   = ng_reg[OB] ? (OB'(1) << (OB - 1)) : ((OB'(1) << (OB - 1)) - 1'b1);
        sat_c = ov_reg[OB] || (qb_reg[OB] > lim);
        qv    = sat_c ? lim : qb_reg[OB];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg   <= ng_reg[OB] ? $signed(-qv) : $signed(qv);
            sat_reg <= sat_c;
        end
    end

    assign q   = q_reg;
    assign sat = sat_reg;

endmodule

>>> hw/rtl/segi_back.sv
// Back half: pulls items from the front queue and runs both coordinate
// divisions in lockstep. Uses segi_pkg and segi_div.
module segi_back #(
    parameter int C = 16,
    parameter int F = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic                                 in_hit,
    input  logic                                 in_par,
    input  logic signed [3*C+2:0]                in_numx,
    input  logic signed [3*C+2:0]                in_numy,
    input  logic signed [2*C+2:0]                in_det,
    output logic                                 out_valid,
    output logic                                 out_hit,
    output logic                                 out_par,
    output logic signed [segi_pkg::OUT_BITS-1:0] out_x,
    output logic signed [segi_pkg::OUT_BITS-1:0] out_y,
    output logic                                 out_sat
);
    localparam int LAT = segi_pkg::DIV_LAT;

    logic [LAT-1:0] v_reg;
    logic [LAT-1:0] hit_reg, par_reg;
    logic signed [segi_pkg::OUT_BITS-1:0] qx, qy;
    logic sx, sy;

    segi_div #(.C(C), .F(F)) u_divx (
        .clk (clk), .en (en), .num (in_numx), .den (in_det), .q (qx), .sat (sx)
    );

    segi_div #(.C(C), .F(F)) u_divy (
        .clk (clk), .en (en), .num (in_numy), .den (in_det), .q (qy), .sat (sy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= {hit_reg[LAT-2:0], in_hit};
            par_reg <= {par_reg[LAT-2:0], in_par};
        end
    end

    // parallel lines report a zero point and no clamp
    assign out_valid = v_reg[LAT-1];
    assign out_hit   = hit_reg[LAT-1];
    assign out_par   = par_reg[LAT-1];
    assign out_x     = par_reg[LAT-1] ? '0 : qx;
    assign out_y     = par_reg[LAT-1] ? '0 : qy;
    assign out_sat   = !par_reg[LAT-1] && (sx || sy);

endmodule

>>> test/testbench.sv
// Self-checking testbench for segment_intersection: predicts each result
// from the endpoints and compares it with what the block returns.
// Depends on segi_pkg and the segment_intersection RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int IN_BITS  = segi_pkg::IN_BITS;
    localparam int OUT_BITS = segi_pkg::OUT_BITS;
    localparam int CB = 16;
    localparam int FB = 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [IN_BITS-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    } seg_pair_t;

    typedef struct packed {
        logic                       hit;
        logic                       parallel;
        logic signed [OUT_BITS-1:0] cross_x;
        logic signed [OUT_BITS-1:0] cross_y;
        logic                       point_saturated;
    } crossing_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic empty;
    logic pop;
    logic [IN_BITS-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    logic hit, parallel, point_saturated;
    logic signed [OUT_BITS-1:0] cross_x, cross_y;

    seg_pair_t pending_pairs[$];
    crossing_t expected_crossings[$];
    int  errors;
    int  idle_cycles;
    bit  hold_sender;
    bit  hold_receiver;
    int  burst_left;
    int  gap_left;
    int  stall_left;

    segment_intersection #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .ax0(ax0), .ay0(ay0), .ax1(ax1), .ay1(ay1),
        .bx0(bx0), .by0(by0), .bx1(bx1), .by1(by1),
        .empty(empty), .pop(pop), .hit(hit), .parallel(parallel),
        .cross_x(cross_x), .cross_y(cross_y), .point_saturated(point_saturated)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic longint coord(logic [IN_BITS-1:0] v);
        return longint'($signed(v[CB-1:0]));
    endfunction

    // (num * 2^FB) / den truncated toward zero, clamped to OUT_BITS
    function automatic longint fixed_quotient(logic signed [127:0] num, longint den,
                                              ref bit sat);
        logic signed [127:0] q;
        longint hi_lim;
        longint lo_lim;
        hi_lim = (longint'(1) <<< (OUT_BITS - 1)) - 1;
        lo_lim = -(longint'(1) <<< (OUT_BITS - 1));
        q = (num <<< FB) / 128'(signed'(den));
        if (q > 128'(signed'(hi_lim)))
        begin
            sat = 1'b1;
            return hi_lim;
        end
        if (q < 128'(signed'(lo_lim)))
        begin
            sat = 1'b1;
            return lo_lim;
        end
        return longint'(q);
    endfunction

    function automatic bit strictly_left(longint p0x, longint p0y, longint p1x,
                                         longint p1y, longint ex, longint ey);
        return ((p0x - ex) * (p1y - p0y) - (p0y - ey) * (p1x - p0x)) > 0;
    endfunction

    function automatic crossing_t predict_crossing(seg_pair_t s);
        crossing_t r;
        longint a0x, a0y, a1x, a1y, b0x, b0y, b1x, b1y;
        longint xda, xdb, yda, ydb, det, da, db;
        logic signed [127:0] nx, ny;
        bit sat;
        bit diffa, diffb;
        a0x = coord(s.ax0); a0y = coord(s.ay0); a1x = coord(s.ax1); a1y = coord(s.ay1);
        b0x = coord(s.bx0); b0y = coord(s.by0); b1x = coord(s.bx1); b1y = coord(s.by1);
        xda = a0x - a1x; xdb = b0x - b1x;
        yda = a0y - a1y; ydb = b0y - b1y;
        det = xda * ydb - xdb * yda;
        r = '0;
        if (det == 0)
        begin
            r.parallel = 1'b1;
            return r;
        end
        sat = 1'b0;
        da = a0x * a1y - a0y * a1x;
        db = b0x * b1y - b0y * b1x;
        nx = 128'(signed'(da)) * 128'(signed'(xdb)) - 128'(signed'(db)) * 128'(signed'(xda));
        ny = 128'(signed'(da)) * 128'(signed'(ydb)) - 128'(signed'(db)) * 128'(signed'(yda));
        r.cross_x = OUT_BITS'(fixed_quotient(nx, det, sat));
        r.cross_y = OUT_BITS'(fixed_quotient(ny, det, sat));
        diffa = strictly_left(a0x, a0y, a1x, a1y, b0x, b0y)
                != strictly_left(a0x, a0y, a1x, a1y, b1x, b1y);
        diffb = strictly_left(b0x, b0y, b1x, b1y, a0x, a0y)
                != strictly_left(b0x, b0y, b1x, b1y, a1x, a1y);
        r.hit = diffa && diffb;
        r.point_saturated = sat;
        return r;
    endfunction

    function automatic seg_pair_t make_pair(int a0x, int a0y, int a1x, int a1y,
                                            int b0x, int b0y, int b1x, int b1y);
        seg_pair_t s;
        s.ax0 = IN_BITS'(a0x); s.ay0 = IN_BITS'(a0y);
        s.ax1 = IN_BITS'(a1x); s.ay1 = IN_BITS'(a1y);
        s.bx0 = IN_BITS'(b0x); s.by0 = IN_BITS'(b0y);
        s.bx1 = IN_BITS'(b1x); s.by1 = IN_BITS'(b1y);
        return s;
    endfunction

    function automatic logic [IN_BITS-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return IN_BITS'($urandom_range(0, 15) - 8);
            1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            2:       return IN_BITS'($urandom_range(0, 511) - 256);
            default: return IN_BITS'($urandom);
        endcase
    endfunction

    function automatic seg_pair_t random_pair();
        seg_pair_t s;
        int kind;
        s = {$urandom, $urandom, $urandom, $urandom};
        kind = $urandom_range(0, 9);
        s.ax0 = rand_coord(); s.ay0 = rand_coord();
        s.ax1 = rand_coord(); s.ay1 = rand_coord();
        s.bx0 = rand_coord(); s.by0 = rand_coord();
        s.bx1 = rand_coord(); s.by1 = rand_coord();
        if (kind == 0)
        begin
            // B parallel to A, shifted
            s.bx1 = s.bx0 + (s.ax1 - s.ax0);
            s.by1 = s.by0 + (s.ay1 - s.ay0);
        end
        else if (kind == 1)
        begin
            // crossing near the origin: small coordinates, likely hit
            s = make_pair(-$urandom_range(1, 300), -$urandom_range(1, 300),
                          $urandom_range(1, 300), $urandom_range(1, 300),
                          -$urandom_range(1, 300), $urandom_range(1, 300),
                          $urandom_range(1, 300), -$urandom_range(1, 300));
        end
        else if (kind == 2)
        begin
            // endpoint of B on line A
            s.bx0 = s.ax0; s.by0 = s.ay0;
        end
        return s;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            {ax0, ay0, ax1, ay1, bx0, by0, bx1, by1} <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (push && !full)
            begin
                expected_crossings.push_back(predict_crossing(
                    {ax0, ay0, ax1, ay1, bx0, by0, bx1, by1}));
                void'(pending_pairs.pop_front());
            end
            if (push && full)
                ;   // keep offering the same item
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                push <= 1'b0;
            end
            else if (hold_sender || pending_pairs.size() == 0)
                push <= 1'b0;
            else
            begin
                {ax0, ay0, ax1, ay1, bx0, by0, bx1, by1} <= pending_pairs[0];
                push <= 1'b1;
                if (burst_left <= 0)
                begin
                    burst_left <= $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
                    gap_left <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // monitor and receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            stall_left <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (pop && !empty)
            begin
                if (expected_crossings.size() == 0)
                begin
                    $display("%0t: result with nothing expected", $time);
                    errors++;
                end
                else
                begin
                    crossing_t e;
                    e = expected_crossings.pop_front();
                    if (hit !== e.hit)
                    begin
                        $display("%0t: hit exp %0b got %0b", $time, e.hit, hit);
                        errors++;
                    end
                    if (parallel !== e.parallel)
                    begin
                        $display("%0t: parallel exp %0b got %0b", $time, e.parallel,
                                 parallel);
                        errors++;
                    end
                    if (cross_x !== e.cross_x)
                    begin
                        $display("%0t: cross_x exp %0d got %0d", $time, e.cross_x, cross_x);
                        errors++;
                    end
                    if (cross_y !== e.cross_y)
                    begin
                        $display("%0t: cross_y exp %0d got %0d", $time, e.cross_y, cross_y);
                        errors++;
                    end
                    if (point_saturated !== e.point_saturated)
                    begin
                        $display("%0t: point_saturated exp %0b got %0b", $time,
                                 e.point_saturated, point_saturated);
                        errors++;
                    end
                end
            end
            if (hold_receiver)
                pop <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                pop <= 1'b0;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                stall_left <= $urandom_range(1, 10);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // long receiver hold while the sender keeps offering
    initial
    begin
        hold_receiver = 1'b0;
        wait (rst_n);
        repeat (300) @(posedge clk);
        hold_receiver = 1'b1;
        repeat (150) @(posedge clk);
        hold_receiver = 1'b0;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** segment_intersection: FAILED **");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        hold_sender = 1'b0;
        rst_n = 1'b0;
        // directed cases
        pending_pairs.push_back(make_pair(-10, 0, 10, 0, 0, -10, 0, 10));      // plain cross
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 0, 5, 10, 5));          // parallel
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 2, 0, 20, 0));          // collinear overlap
        pending_pairs.push_back(make_pair(3, 3, 3, 3, 0, 0, 5, 7));            // zero length
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 5, 10));          // endpoint on line
        pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 10, 10, 0));        // diagonal cross
        pending_pairs.push_back(make_pair(0, 0, 1, 1, 5, 0, 6, 2));            // lines meet off segs
        pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                          -32768, 32767, 32767, -32768));      // extreme cross
        pending_pairs.push_back(make_pair(-32768, 0, -32767, 1, 32767, 0, 32767, 1));
        pending_pairs.push_back(make_pair(0, 0, 32767, 1, 0, 1, 32767, 3));    // far, not saturated
        pending_pairs.push_back(make_pair(0, 0, -32768, 1, 0, 1, -32768, 3));
        pending_pairs.push_back(make_pair(32767, -32768, -32768, 32767,
                                          32767, 32767, -32768, -32768));
        pending_pairs.push_back(make_pair(0, 0, 3, 1, 1, 0, 0, 3));            // fractional point
        pending_pairs.push_back(make_pair(0, 0, -3, 1, -1, 0, 0, -3));         // negative fraction
        pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
        pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767, 0, 0, 1, 1));
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < 600; i++)
        begin
            if (i == 300)
            begin
                // let everything drain before continuing
                wait (pending_pairs.size() == 0);
                hold_sender = 1'b1;
                wait (pending_pairs.size() == 0 && expected_crossings.size() == 0
                      && !push);
                hold_sender = 1'b0;
            end
            pending_pairs.push_back(random_pair());
        end
        wait (pending_pairs.size() == 0 && expected_crossings.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_crossings.size() == 0)
            $display("** segment_intersection: PASSED **");
        else
            $display("** segment_intersection: FAILED **");
        $finish;
    end

endmodule
